// ===== rtl/core/wspg_pkg.sv =====
// Shared types, codes and helpers for the workspace safety point gate.
package wspg_pkg;

  // Q15.16 coordinate
  typedef logic signed [31:0] coord_t;

  // input word: one raw target point
  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_word_t;

  // result word: verdict and commanded point
  typedef struct packed {
    logic               accepted;
    logic [2:0]         verdict;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_word_t;

  // flags from the radius checker, aligned with the decision stage
  typedef struct packed {
    logic collide;
    logic reach;
  } chk_flags_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLL_RAD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLL_HGT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REACH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REJOIN   = 3'd6;

  // phase codes, also carried down the pipe as the kind of each word
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_RUN    = 2'd2;

  // verdict codes
  localparam logic [2:0] V_OFFSET  = 3'd0;
  localparam logic [2:0] V_JUMP    = 3'd1;
  localparam logic [2:0] V_ACCEPT  = 3'd2;
  localparam logic [2:0] V_COLLIDE = 3'd3;
  localparam logic [2:0] V_REACH   = 3'd4;
  localparam logic [2:0] V_FAR     = 3'd5;

  // clamp a 34-bit signed value to the signed 32-bit range
  function automatic coord_t sat34(input logic signed [33:0] v);
    coord_t r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // magnitude of a signed coordinate (full range, -2^31 gives 2^31)
  function automatic logic [31:0] mag32(input coord_t v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

endpackage

// ===== rtl/core/workspace_safety_point_gate.sv =====
// Workspace safety point gate: offset/jump capture, then safety checks per point.
//
// Input channel (in_valid / in_stall / in_data) takes one Q15.16 target point
// per word. Result channel (out_valid / out_stall / out_data) gives exactly
// one word per input point: accepted flag, verdict code and the commanded
// point (zero unless accepted). The first point after reset captures the
// offset from the base pose, the second the jump; later points are shifted,
// checked for self-collision, overextension and rejoin distance.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata), used
// while no points are in flight.
// Throughput: one point per cycle while out_stall is low; the pipe is five
// register stages (input, shifted point, squares, compares, result) moving
// on one enable. The rejoin check and its last-good update close a loop
// inside the final stage, so that stage alone decides each point.
// Reset (synchronous, rst_n low) empties the pipe, restores the register
// defaults and returns to waiting for the first point.
// When the receiver stalls with a result waiting, the whole pipe holds and
// in_stall rises; it drops as soon as the result word is taken.
module workspace_safety_point_gate (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  wspg_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output wspg_pkg::out_word_t           out_data,
  input  logic                          cfg_we,
  input  logic [wspg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);
  import wspg_pkg::*;

  // configuration registers
  coord_t      base_r [3];
  logic [30:0] coll_rad_r;
  coord_t      coll_hgt_r;
  logic [30:0] reach_rad_r;
  logic [30:0] rejoin_r;
  logic [61:0] lim2_r;

  // control
  logic       en;
  logic       in_accept;
  logic [1:0] phase_r;

  // captured vectors
  coord_t offset_r [3];
  coord_t first_r  [3];
  coord_t jump_r   [3];
  coord_t last_good_r [3];
  logic   blocked_r;

  // pipeline stages
  logic       s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [1:0] s1_kind_r, s2_kind_r, s3_kind_r, s4_kind_r;
  in_word_t   s1_data_r;
  coord_t     s1_p [3];
  coord_t     c_run [3];
  logic signed [33:0] c_sum [3];
  coord_t     s2_c_r [3];
  coord_t     s3_c_r [3];
  coord_t     s4_c_r [3];
  chk_flags_t s4_flags;

  // decision stage
  logic signed [32:0] d_diff [3];
  logic [32:0]        d_mag  [3];
  logic [61:0]        d_sq   [3];
  logic [63:0]        d2;
  logic               d_big;
  logic               near;
  logic               acc;
  logic [2:0]         verdict;
  logic               set_block;
  logic               out_valid_r;
  out_word_t          out_data_r;

  // handshake: the pipe moves unless a result is waiting and stalled
  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign in_accept = in_valid && en;

  // configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r[0]   <= '0;
      base_r[1]   <= '0;
      base_r[2]   <= '0;
      coll_rad_r  <= '0;
      coll_hgt_r  <= '0;
      reach_rad_r <= 31'h7FFF_FFFF;
      rejoin_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_X:   base_r[0]   <= cfg_wdata;
        REG_BASE_Y:   base_r[1]   <= cfg_wdata;
        REG_BASE_Z:   base_r[2]   <= cfg_wdata;
        REG_COLL_RAD: coll_rad_r  <= cfg_wdata[30:0];
        REG_COLL_HGT: coll_hgt_r  <= cfg_wdata;
        REG_REACH:    reach_rad_r <= cfg_wdata[30:0];
        REG_REJOIN:   rejoin_r    <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // squared rejoin limit
  always_ff @(posedge clk) begin
    lim2_r <= rejoin_r * rejoin_r;
  end

  // phase: first point, second point, then running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
    end else if (in_accept) begin
      unique case (phase_r)
        PH_FIRST:  phase_r <= PH_SECOND;
        PH_SECOND: phase_r <= PH_RUN;
        default:   phase_r <= PH_RUN;
      endcase
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (en) begin
      s1_data_r <= in_data;
      s1_kind_r <= phase_r;
    end
  end

  assign s1_p[0] = s1_data_r.in_x;
  assign s1_p[1] = s1_data_r.in_y;
  assign s1_p[2] = s1_data_r.in_z;

  // shifted point: p + offset - jump, clamped
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_sum[i] = 34'(s1_p[i]) + 34'(offset_r[i]) - 34'(jump_r[i]);
      c_run[i] = sat34(c_sum[i]);
    end
  end

  // offset and jump capture; written here so the next word sees them
  always_ff @(posedge clk) begin
    if (en && s1_v_r) begin
      case (s1_kind_r)
        PH_FIRST: begin
          for (int i = 0; i < 3; i++) begin
            offset_r[i] <= sat34(34'(base_r[i]) - 34'(s1_p[i]));
            first_r[i]  <= s1_p[i];
          end
        end
        PH_SECOND: begin
          for (int i = 0; i < 3; i++) begin
            jump_r[i] <= sat34(34'(s1_p[i]) - 34'(first_r[i]));
          end
        end
        default: ;
      endcase
    end
  end

  // stages 2 to 4: carry the kind and shifted point alongside the checker
  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind_r <= s1_kind_r;
      s3_kind_r <= s2_kind_r;
      s4_kind_r <= s3_kind_r;
      for (int i = 0; i < 3; i++) begin
        s2_c_r[i] <= c_run[i];
        s3_c_r[i] <= s2_c_r[i];
        s4_c_r[i] <= s3_c_r[i];
      end
    end
  end

  wspg_radius_check u_radius_check (
    .clk              (clk),
    .en               (en),
    .c_x              (s2_c_r[0]),
    .c_y              (s2_c_r[1]),
    .c_z              (s2_c_r[2]),
    .collision_radius (coll_rad_r),
    .collision_height (coll_hgt_r),
    .reach_radius     (reach_rad_r),
    .flags            (s4_flags)
  );

  // rejoin distance from the last accepted point
  always_comb begin
    d_big = 1'b0;
    d2    = '0;
    for (int i = 0; i < 3; i++) begin
      d_diff[i] = 33'(s4_c_r[i]) - 33'(last_good_r[i]);
      d_mag[i]  = d_diff[i][32] ? 33'(-d_diff[i]) : 33'(d_diff[i]);
      d_sq[i]   = d_mag[i][30:0] * d_mag[i][30:0];
      if (d_mag[i][32:31] != 2'b00) begin
        d_big = 1'b1;
      end
      d2 = d2 + 64'(d_sq[i]);
    end
    near = !d_big && (d2 < {2'b00, lim2_r});
  end

  // verdict
  always_comb begin
    acc       = 1'b0;
    set_block = 1'b0;
    case (s4_kind_r)
      PH_FIRST:  verdict = V_OFFSET;
      PH_SECOND: verdict = V_JUMP;
      default: begin
        if (s4_flags.collide) begin
          verdict   = V_COLLIDE;
          set_block = 1'b1;
        end else if (s4_flags.reach) begin
          verdict   = V_REACH;
          set_block = 1'b1;
        end else if (blocked_r && !near) begin
          verdict = V_FAR;
        end else begin
          verdict = V_ACCEPT;
          acc     = 1'b1;
        end
      end
    endcase
  end

  // blocked flag and last accepted point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocked_r      <= 1'b0;
      last_good_r[0] <= '0;
      last_good_r[1] <= '0;
      last_good_r[2] <= '0;
    end else if (en && s4_v_r) begin
      if (set_block) begin
        blocked_r <= 1'b1;
      end else if (acc) begin
        blocked_r <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          last_good_r[i] <= s4_c_r[i];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.accepted <= acc;
      out_data_r.verdict  <= verdict;
      out_data_r.out_x    <= acc ? s4_c_r[0] : '0;
      out_data_r.out_y    <= acc ? s4_c_r[1] : '0;
      out_data_r.out_z    <= acc ? s4_c_r[2] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/wspg_radius_check.sv =====
// Two-stage radius checker: squares, then collision and reach compares.
module wspg_radius_check (
  input  logic                 clk,
  input  logic                 en,
  input  wspg_pkg::coord_t     c_x,
  input  wspg_pkg::coord_t     c_y,
  input  wspg_pkg::coord_t     c_z,
  input  logic [30:0]          collision_radius,
  input  wspg_pkg::coord_t     collision_height,
  input  logic [30:0]          reach_radius,
  output wspg_pkg::chk_flags_t flags
);
  import wspg_pkg::*;

  logic [61:0] cr2_r;
  logic [61:0] rr2_r;
  logic [63:0] sqx_r, sqy_r, sqz_r;
  logic        z_low_r;
  chk_flags_t  flags_r;
  logic [63:0] xy;
  logic [63:0] xyz;

  // squared limits; user moves config only while pipe is empty (unchecked)
  always_ff @(posedge clk) begin
    cr2_r <= collision_radius * collision_radius;
    rr2_r <= reach_radius * reach_radius;
  end

  // stage A: squares and the height compare
  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r   <= mag32(c_x) * mag32(c_x);
      sqy_r   <= mag32(c_y) * mag32(c_y);
      sqz_r   <= mag32(c_z) * mag32(c_z);
      z_low_r <= (c_z < collision_height);
    end
  end

  // stage B: radius sums against the squared limits (sums stay below 2^64)
  assign xy  = sqx_r + sqy_r;
  assign xyz = xy + sqz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      flags_r.collide <= (xy < {2'b00, cr2_r}) && z_low_r;
      flags_r.reach   <= (xyz > {2'b00, rr2_r});
    end
  end

  assign flags = flags_r;

endmodule
